[hw/rtl/pfa_pkg.sv]
// Shared types and constants of the packed field array.
package pfa_pkg;

  localparam int INDEX_W   = 15;
  localparam int VALUE_W   = 32;
  localparam int FW_W      = 6;
  localparam int COUNT_W   = 16;
  localparam int PROD_W    = INDEX_W + FW_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

  localparam logic [FW_W-1:0]    FIELD_WIDTH_MIN = 6'd1;
  localparam logic [FW_W-1:0]    FIELD_WIDTH_MAX = 6'd32;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 16'd1024;

  typedef struct packed {
    logic               operation;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } pfa_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               error;
  } pfa_rsp_t;

endpackage

[hw/rtl/packed_field_array.sv]
// Top level of the packed field array: configuration, sequencer and response register.
// The block stores entries of field_width bits (1 to 32) packed back to back
// from bit 0 upward in a store of STORE_WORDS words of WORD_BITS bits, so an
// entry may straddle word boundaries. A request word either reads an entry
// (read_value returns it) or writes one (only the low field_width bits of
// value are stored, neighboring bits are kept, read_value is zero). An index
// at or above entry_count, or an entry that would reach past the end of the
// store, returns error with read_value zero and leaves the store untouched.
// Items are handled one at a time. After acceptance the sequencer checks the
// bounds, then the bit offset index * field_width is split into word address
// and bit position by a reciprocal multiplication; then every memory word the
// entry touches is read in one state and merged and written back in the next,
// and last the response register is loaded. With the default 32-bit words an
// entry touches one or two words. A refused item goes from the bounds check
// straight to loading the response.
// A finished response word sits in an output register, so the next request
// is taken while the response still waits for rsp_ready; a second finished
// response waits in the sequencer until the first one leaves. The store has no
// reset; an entry must be written before it is read. Configuration writes
// are always accepted and must only be issued while the block is idle.
module packed_field_array
  import pfa_pkg::*;
#(
  parameter int STORE_WORDS = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  pfa_req_t              req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output pfa_rsp_t              rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int     AW       = $clog2(STORE_WORDS);
  localparam int     BP_W     = $clog2(WORD_BITS);
  localparam longint CAP      = longint'(STORE_WORDS) * longint'(WORD_BITS);
  localparam int     CAP_W    = $clog2(CAP + 1);
  localparam int     END_W    = PROD_W + 1;
  localparam int     CMP_W    = (CAP_W > END_W) ? CAP_W : END_W;
  localparam int     WMAX     = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
  localparam int     N_W      = $clog2(WMAX + 1);
  localparam int     SPAN_W   = WORD_BITS + VALUE_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]         state;
  logic [FW_W-1:0]    field_width;
  logic [COUNT_W-1:0] entry_count;
  logic [FW_W-1:0]    w_eff;

  logic               cur_op;
  logic [INDEX_W-1:0] cur_index;
  logic [VALUE_W-1:0] cur_value;
  logic [FW_W-1:0]    cur_width;
  logic [PROD_W-1:0]  offset;
  logic [AW-1:0]      word_addr;
  logic [BP_W-1:0]    bit_pos;
  logic [FW_W-1:0]    remaining;
  logic [FW_W-1:0]    done_bits;
  logic [VALUE_W-1:0] acc;
  logic               err;

  logic               range_err;
  logic [CMP_W-1:0]   end_c;
  logic               div_start;
  logic               div_done;
  logic [PROD_W-1:0]  div_quot;
  logic [BP_W:0]      div_rem;

  logic [N_W-1:0]       room;
  logic [N_W-1:0]       take_n;
  logic [FW_W-1:0]      take_f;
  logic [WORD_BITS-1:0] mask_w;
  logic [WORD_BITS-1:0] piece;
  logic [SPAN_W-1:0]    piece_span;
  logic [SPAN_W-1:0]    val_span;
  logic [WORD_BITS-1:0] seg;
  logic [WORD_BITS-1:0] word_new;

  logic                 mem_rd_en;
  logic                 mem_wr_en;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 fin_load;
  logic                 req_fire;

  // A width of zero behaves as one, anything above 32 as 32.
  always_comb begin
    priority if (field_width == '0) begin
      w_eff = FIELD_WIDTH_MIN;
    end else if (field_width > FIELD_WIDTH_MAX) begin
      w_eff = FIELD_WIDTH_MAX;
    end else begin
      w_eff = field_width;
    end
  end

  // Bounds: the index must be below entry_count and the entry's last bit
  // must lie inside the store.
  assign end_c     = CMP_W'(offset) + CMP_W'(cur_width);
  assign range_err = (COUNT_W'(cur_index) >= entry_count) || (end_c > CMP_W'(CAP));

  // One step of the word loop takes as many entry bits as fit in the
  // current word from the current bit position.
  assign room     = N_W'(WORD_BITS) - N_W'(bit_pos);
  assign take_n   = (N_W'(remaining) < room) ? N_W'(remaining) : room;
  assign take_f   = FW_W'(take_n);
  assign mask_w   = ~({WORD_BITS{1'b1}} << take_n);

  // Read side: move the word's bits down to bit 0, then up to their place
  // in the entry.
  assign piece      = (mem_rd_data >> bit_pos) & mask_w;
  assign piece_span = SPAN_W'(piece) << done_bits;

  // Write side: merge the matching slice of the value into the old word.
  assign val_span = SPAN_W'(cur_value) >> done_bits;
  assign seg      = val_span[WORD_BITS-1:0] & mask_w;
  assign word_new = (mem_rd_data & ~(mask_w << bit_pos)) | (seg << bit_pos);

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cfg_ready = 1'b1;
  assign div_start = (state == S_CHK) && !range_err;
  assign mem_rd_en = (state == S_RD);
  assign mem_wr_en = (state == S_MOD) && (cur_op == OP_WRITE);
  assign fin_load  = (state == S_FIN) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      field_width <= FIELD_WIDTH_MAX;
      entry_count <= ENTRY_COUNT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIELD_WIDTH: field_width <= cfg_data[FW_W-1:0];
          CFG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (fin_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: if (req_fire) state <= S_CHK;
        S_CHK:  state <= range_err ? S_FIN : S_DIV;
        S_DIV:  if (div_done) state <= S_RD;
        S_RD:   state <= S_MOD;
        S_MOD:  state <= (remaining == take_f) ? S_FIN : S_RD;
        S_FIN:  if (fin_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_op    <= req.operation;
      cur_index <= req.index;
      cur_value <= req.value;
      cur_width <= w_eff;
      offset    <= PROD_W'(req.index * w_eff);
    end
    if (state == S_CHK) begin
      err       <= range_err;
      acc       <= '0;
      remaining <= cur_width;
      done_bits <= '0;
    end
    if (div_done) begin
      word_addr <= div_quot[AW-1:0];
      bit_pos   <= div_rem[BP_W-1:0];
    end
    if (state == S_MOD) begin
      acc       <= acc | piece_span[VALUE_W-1:0];
      remaining <= remaining - take_f;
      done_bits <= done_bits + take_f;
      word_addr <= word_addr + 1'b1;
      bit_pos   <= '0;
    end
    if (fin_load) begin
      rsp.read_value <= (err || (cur_op == OP_WRITE)) ? '0 : acc;
      rsp.error      <= err;
    end
  end

  pfa_div #(
    .DIVISOR    (WORD_BITS),
    .DIVIDEND_W (PROD_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (offset),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  pfa_mem #(
    .DEPTH (STORE_WORDS),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (word_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (word_addr),
    .wr_data (word_new)
  );

  // The store is only ever written while serving a write request.
  a_wr_only_on_write: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (cur_op == OP_WRITE) && !err)
    else $error("store written outside a write request");

  // The divider only reports back while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  // Every word visit still has entry bits to move.
  a_word_has_bits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (remaining != '0) && (done_bits + remaining == cur_width))
    else $error("word loop bit count out of step");

  // A refused access never returns data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.error) |-> (rsp.read_value == '0))
    else $error("error response carries data");

  // An accepted request always goes to the bounds check next.
  a_accept_to_chk: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == S_CHK))
    else $error("accepted request skipped the bounds check");

endmodule

[hw/rtl/pfa_mem.sv]
// Word store: one write port and one read port with registered read data.
module pfa_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/pfa_div.sv]
// Division by a fixed divisor through a reciprocal multiplication, result in the cycle after start.
module pfa_div
  import pfa_pkg::*;
#(
  parameter int DIVISOR    = 32,
  parameter int DIVIDEND_W = PROD_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DIVIDEND_W-1:0]       dividend,
  output logic                        done,
  output logic [DIVIDEND_W-1:0]       quotient,
  output logic [$clog2(DIVISOR):0]    remainder
);

  localparam int     RW      = $clog2(DIVISOR) + 1;
  localparam int     SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int     RECIP_W = DIVIDEND_W + 1;
  localparam int     MUL_W   = DIVIDEND_W + RECIP_W;
  // Rounded-up reciprocal; with this shift the quotient is exact for every
  // dividend of DIVIDEND_W bits.
  localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);

  logic [MUL_W-1:0]      product;
  logic [DIVIDEND_W-1:0] held;
  logic [DIVIDEND_W-1:0] multiple;

  assign product   = MUL_W'(dividend) * MUL_W'(RECIP);

  // The remainder is below the divisor, so its low bits are all it needs.
  assign multiple  = DIVIDEND_W'(quotient * DIVIDEND_W'(DIVISOR));
  assign remainder = RW'(held - multiple);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= DIVIDEND_W'(product >> SHIFT);
      held     <= dividend;
    end
  end

endmodule
